// ===== rtl/legik_pkg.sv =====
package legik_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int TAB_LEN          = 24;

    localparam int COORD_W = 13;
    localparam int LEN_W   = 12;
    localparam int OUT_W   = 16;
    localparam int ANG_W   = 24;
    localparam int SUM_W   = 26;
    localparam int IDX_W   = 2;

    localparam int SQ_A_W = 30;
    localparam int SQ_C_W = 60;

    localparam logic [IDX_W-1:0] REG_COXA  = 2'd0;
    localparam logic [IDX_W-1:0] REG_FEMUR = 2'd1;
    localparam logic [IDX_W-1:0] REG_TIBIA = 2'd2;

    localparam logic [LEN_W-1:0] COXA_RST  = 12'd480;
    localparam logic [LEN_W-1:0] FEMUR_RST = 12'd944;
    localparam logic [LEN_W-1:0] TIBIA_RST = 12'd1152;

    localparam logic signed [ANG_W-1:0] HALF_PI_Q = 24'sd1647099;
    localparam logic signed [SUM_W-1:0] PI_Q      = 26'sd3294199;
    localparam logic signed [SUM_W-1:0] TWO_PI_Q  = 26'sd6588398;

    localparam logic signed [ANG_W-1:0] ATAN_TAB [0:TAB_LEN-1] = '{
        24'sd823550, 24'sd486170, 24'sd256879, 24'sd130396,
        24'sd65451,  24'sd32757,  24'sd16383,  24'sd8192,
        24'sd4096,   24'sd2048,   24'sd1024,   24'sd512,
        24'sd256,    24'sd128,    24'sd64,     24'sd32,
        24'sd16,     24'sd8,      24'sd4,      24'sd2,
        24'sd1,      24'sd0,      24'sd0,      24'sd0
    };

    function automatic logic [OUT_W-1:0] round_angle(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] t;
        t = v + 26'sd128;
        return t[23:8];
    endfunction

endpackage

// ===== rtl/leg_inverse_kinematics_3dof_unit.sv =====
// Channel    Dir  Handshake          Payload
// s_ target  in   s_tvalid/s_tready  s_tdata: target_x, target_y, target_z
// m_ angles  out  m_tvalid/m_tready  m_tdata: hip, knee, ankle; m_tuser: unreachable
// cfg        in   cfg_wr_en          cfg_index, cfg_wdata
//
// One item enters per clock while the skid register is empty; the path runs through
// the three square root chains in series (15, 15 and 30 bit steps) and the CORDIC steps.
// Reset is synchronous and active low; it restores the segment lengths.
// A full output register followed by one more item parks it in a skid register,
// and the whole pipeline holds until the output register is taken.
module leg_inverse_kinematics_3dof_unit #(
    parameter int CORDIC_STEPS = legik_pkg::CORDIC_STEPS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [39:0]                    s_tdata,   // target_x, target_y, target_z, pad
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [47:0]                    m_tdata,   // hip_angle, knee_angle, ankle_angle
    output logic [0:0]                     m_tuser,   // unreachable
    input  logic                           cfg_wr_en,
    input  logic [legik_pkg::IDX_W-1:0]    cfg_index,
    input  logic [legik_pkg::LEN_W-1:0]    cfg_wdata
);

    localparam int SQ_A_RT = legik_pkg::SQ_A_W / 2;
    localparam int SQ_C_RT = legik_pkg::SQ_C_W / 2;

    logic en;
    logic s_acc;
    logic out_free;

    logic [legik_pkg::LEN_W-1:0] coxa_len_reg;
    logic [legik_pkg::LEN_W-1:0] femur_len_reg;
    logic [legik_pkg::LEN_W-1:0] tibia_len_reg;
    logic [13:0] cu;
    logic [13:0] fu;
    logic [13:0] tu;

    assign cu = {coxa_len_reg, 2'b00};
    assign fu = {femur_len_reg, 2'b00};
    assign tu = {tibia_len_reg, 2'b00};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coxa_len_reg  <= legik_pkg::COXA_RST;
            femur_len_reg <= legik_pkg::FEMUR_RST;
            tibia_len_reg <= legik_pkg::TIBIA_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                legik_pkg::REG_COXA:  coxa_len_reg  <= cfg_wdata;
                legik_pkg::REG_FEMUR: femur_len_reg <= cfg_wdata;
                legik_pkg::REG_TIBIA: tibia_len_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    logic skid_valid_reg;
    assign en       = ~skid_valid_reg;
    assign s_tready = en;
    assign s_acc    = s_tvalid & en;

    // Stage 1: input register.
    logic               p1_valid_reg;
    logic signed [12:0] p1_x_reg;
    logic signed [12:0] p1_y_reg;
    logic signed [12:0] p1_z_reg;

    // Stage 2: squared radius in the horizontal plane.
    logic               p2_valid_reg;
    logic [29:0]        p2_q_reg;
    logic signed [14:0] p2_zu_reg;
    logic signed [13:0] p2_hy_reg;
    logic signed [13:0] p2_hx_reg;
    logic signed [25:0] xx;
    logic signed [25:0] yy;
    logic [25:0]        rr;

    assign xx = p1_x_reg * p1_x_reg;
    assign yy = p1_y_reg * p1_y_reg;
    assign rr = $unsigned(xx) + $unsigned(yy);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
        end else if (en) begin
            p1_valid_reg <= s_acc;
            p2_valid_reg <= p1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p1_x_reg  <= s_tdata[12:0];
            p1_y_reg  <= s_tdata[25:13];
            p1_z_reg  <= s_tdata[38:26];
            p2_q_reg  <= {rr, 4'b0000};
            p2_zu_reg <= {p1_z_reg, 2'b00};
            p2_hy_reg <= 14'(p1_x_reg) + 14'(p1_y_reg);
            p2_hx_reg <= 14'(p1_x_reg) - 14'(p1_y_reg);
        end
    end

    logic               sa_valid;
    logic [SQ_A_RT-1:0] sa_root;
    logic [42:0]        sa_side;

    legik_isqrt #(
        .IN_W   (legik_pkg::SQ_A_W),
        .SIDE_W (43)
    ) u_sqrt_r (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (p2_valid_reg),
        .in_rad    (p2_q_reg),
        .in_side   ({p2_zu_reg, p2_hy_reg, p2_hx_reg}),
        .out_valid (sa_valid),
        .out_root  (sa_root),
        .out_side  (sa_side)
    );

    // Stages 3 to 5: offset from the coxa, squares and the cosine-law terms.
    logic               p3_valid_reg;
    logic signed [16:0] p3_d_reg;
    logic signed [14:0] p3_zu_reg;
    logic signed [13:0] p3_hy_reg;
    logic signed [13:0] p3_hx_reg;

    logic               p4_valid_reg;
    logic [29:0]        p4_d2_reg;
    logic [28:0]        p4_z2_reg;
    logic [27:0]        p4_f2_reg;
    logic [27:0]        p4_t2_reg;
    logic [28:0]        p4_den3_reg;
    logic signed [16:0] p4_d_reg;
    logic signed [14:0] p4_zu_reg;
    logic signed [13:0] p4_hy_reg;
    logic signed [13:0] p4_hx_reg;

    logic               p5_valid_reg;
    logic [29:0]        p5_sum_reg;
    logic signed [33:0] p5_num_reg;
    logic signed [33:0] p5_num3_reg;
    logic [28:0]        p5_den3_reg;
    logic signed [16:0] p5_d_reg;
    logic signed [14:0] p5_zu_reg;
    logic signed [13:0] p5_hy_reg;
    logic signed [13:0] p5_hx_reg;

    logic signed [33:0] d2_full;
    logic signed [29:0] z2_full;
    logic [27:0]        f2;
    logic [27:0]        t2;
    logic [27:0]        ft;
    logic [29:0]        sum_dz;
    logic signed [33:0] num_next;
    logic signed [33:0] num3_next;

    assign d2_full   = p3_d_reg * p3_d_reg;
    assign z2_full   = p3_zu_reg * p3_zu_reg;
    assign f2        = fu * fu;
    assign t2        = tu * tu;
    assign ft        = fu * tu;
    assign sum_dz    = p4_d2_reg + 30'(p4_z2_reg);
    assign num_next  = $signed(34'(p4_f2_reg)) + $signed(34'(sum_dz))
                     - $signed(34'(p4_t2_reg));
    assign num3_next = $signed(34'(p4_f2_reg)) + $signed(34'(p4_t2_reg))
                     - $signed(34'(sum_dz));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p3_valid_reg <= 1'b0;
            p4_valid_reg <= 1'b0;
            p5_valid_reg <= 1'b0;
        end else if (en) begin
            p3_valid_reg <= sa_valid;
            p4_valid_reg <= p3_valid_reg;
            p5_valid_reg <= p4_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p3_d_reg    <= $signed({2'b00, sa_root}) - $signed({3'b000, cu});
            p3_zu_reg   <= sa_side[42:28];
            p3_hy_reg   <= sa_side[27:14];
            p3_hx_reg   <= sa_side[13:0];
            p4_d2_reg   <= d2_full[29:0];
            p4_z2_reg   <= z2_full[28:0];
            p4_f2_reg   <= f2;
            p4_t2_reg   <= t2;
            p4_den3_reg <= {ft, 1'b0};
            p4_d_reg    <= p3_d_reg;
            p4_zu_reg   <= p3_zu_reg;
            p4_hy_reg   <= p3_hy_reg;
            p4_hx_reg   <= p3_hx_reg;
            p5_sum_reg  <= sum_dz;
            p5_num_reg  <= num_next;
            p5_num3_reg <= num3_next;
            p5_den3_reg <= p4_den3_reg;
            p5_d_reg    <= p4_d_reg;
            p5_zu_reg   <= p4_zu_reg;
            p5_hy_reg   <= p4_hy_reg;
            p5_hx_reg   <= p4_hx_reg;
        end
    end

    logic               sb_valid;
    logic [SQ_A_RT-1:0] sb_root;
    logic [156:0]       sb_side;

    legik_isqrt #(
        .IN_W   (legik_pkg::SQ_A_W),
        .SIDE_W (157)
    ) u_sqrt_s (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (p5_valid_reg),
        .in_rad    (p5_sum_reg),
        .in_side   ({p5_num_reg, p5_num3_reg, p5_den3_reg, p5_d_reg,
                     p5_zu_reg, p5_hy_reg, p5_hx_reg}),
        .out_valid (sb_valid),
        .out_root  (sb_root),
        .out_side  (sb_side)
    );

    // Stages 6 to 8: denominators, reach check and the acos radicands.
    logic               p6_valid_reg;
    logic [29:0]        p6_den_reg;
    logic signed [33:0] p6_num_reg;
    logic signed [33:0] p6_num3_reg;
    logic [28:0]        p6_den3_reg;
    logic signed [16:0] p6_d_reg;
    logic signed [14:0] p6_zu_reg;
    logic signed [13:0] p6_hy_reg;
    logic signed [13:0] p6_hx_reg;

    logic               p7_valid_reg;
    logic [31:0]        p7_a1_reg;
    logic [31:0]        p7_b1_reg;
    logic [31:0]        p7_a3_reg;
    logic [31:0]        p7_b3_reg;
    logic               p7_bad_reg;
    logic signed [33:0] p7_num_reg;
    logic signed [33:0] p7_num3_reg;
    logic signed [16:0] p7_d_reg;
    logic signed [14:0] p7_zu_reg;
    logic signed [13:0] p7_hy_reg;
    logic signed [13:0] p7_hx_reg;

    logic               p8_valid_reg;
    logic [59:0]        p8_mm1_reg;
    logic [59:0]        p8_mm3_reg;
    logic               p8_bad_reg;
    logic signed [33:0] p8_num_reg;
    logic signed [33:0] p8_num3_reg;
    logic signed [16:0] p8_d_reg;
    logic signed [14:0] p8_zu_reg;
    logic signed [13:0] p8_hy_reg;
    logic signed [13:0] p8_hx_reg;

    logic [28:0]        fs;
    logic signed [34:0] a1;
    logic signed [34:0] b1;
    logic signed [34:0] a3;
    logic signed [34:0] b3;
    logic               bad_next;
    logic [63:0]        mm1;
    logic [63:0]        mm3;

    assign fs = fu * sb_root;
    assign a1 = $signed(35'(p6_den_reg)) - 35'(p6_num_reg);
    assign b1 = $signed(35'(p6_den_reg)) + 35'(p6_num_reg);
    assign a3 = $signed(35'(p6_den3_reg)) - 35'(p6_num3_reg);
    assign b3 = $signed(35'(p6_den3_reg)) + 35'(p6_num3_reg);
    assign bad_next = (p6_den_reg == '0) || (p6_den3_reg == '0) ||
                      a1[34] || b1[34] || a3[34] || b3[34];
    assign mm1 = p7_a1_reg * p7_b1_reg;
    assign mm3 = p7_a3_reg * p7_b3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p6_valid_reg <= 1'b0;
            p7_valid_reg <= 1'b0;
            p8_valid_reg <= 1'b0;
        end else if (en) begin
            p6_valid_reg <= sb_valid;
            p7_valid_reg <= p6_valid_reg;
            p8_valid_reg <= p7_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p6_den_reg  <= {fs, 1'b0};
            p6_num_reg  <= sb_side[156:123];
            p6_num3_reg <= sb_side[122:89];
            p6_den3_reg <= sb_side[88:60];
            p6_d_reg    <= sb_side[59:43];
            p6_zu_reg   <= sb_side[42:28];
            p6_hy_reg   <= sb_side[27:14];
            p6_hx_reg   <= sb_side[13:0];
            p7_a1_reg   <= bad_next ? '0 : a1[31:0];
            p7_b1_reg   <= bad_next ? '0 : b1[31:0];
            p7_a3_reg   <= bad_next ? '0 : a3[31:0];
            p7_b3_reg   <= bad_next ? '0 : b3[31:0];
            p7_bad_reg  <= bad_next;
            p7_num_reg  <= p6_num_reg;
            p7_num3_reg <= p6_num3_reg;
            p7_d_reg    <= p6_d_reg;
            p7_zu_reg   <= p6_zu_reg;
            p7_hy_reg   <= p6_hy_reg;
            p7_hx_reg   <= p6_hx_reg;
            p8_mm1_reg  <= mm1[59:0];
            p8_mm3_reg  <= mm3[59:0];
            p8_bad_reg  <= p7_bad_reg;
            p8_num_reg  <= p7_num_reg;
            p8_num3_reg <= p7_num3_reg;
            p8_d_reg    <= p7_d_reg;
            p8_zu_reg   <= p7_zu_reg;
            p8_hy_reg   <= p7_hy_reg;
            p8_hx_reg   <= p7_hx_reg;
        end
    end

    logic               sc_valid;
    logic [SQ_C_RT-1:0] sc_root;
    logic [93:0]        sc_side;
    logic               sd_valid;
    logic [SQ_C_RT-1:0] sd_root;
    logic [34:0]        sd_side;

    legik_isqrt #(
        .IN_W   (legik_pkg::SQ_C_W),
        .SIDE_W (94)
    ) u_sqrt_knee (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (p8_valid_reg),
        .in_rad    (p8_mm1_reg),
        .in_side   ({p8_num_reg, p8_d_reg, p8_zu_reg, p8_hy_reg, p8_hx_reg}),
        .out_valid (sc_valid),
        .out_root  (sc_root),
        .out_side  (sc_side)
    );

    legik_isqrt #(
        .IN_W   (legik_pkg::SQ_C_W),
        .SIDE_W (35)
    ) u_sqrt_ankle (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (p8_valid_reg),
        .in_rad    (p8_mm3_reg),
        .in_side   ({p8_num3_reg, p8_bad_reg}),
        .out_valid (sd_valid),
        .out_root  (sd_root),
        .out_side  (sd_side)
    );

    logic signed [legik_pkg::ANG_W-1:0] ang_hip;
    logic signed [legik_pkg::ANG_W-1:0] ang_kacos;
    logic signed [legik_pkg::ANG_W-1:0] ang_kdir;
    logic signed [legik_pkg::ANG_W-1:0] ang_ankle;
    logic signed [16:0]                 kd_x;

    assign kd_x = 17'($signed(sc_side[42:28]));

    legik_cordic #(.IN_W(14), .STEPS(CORDIC_STEPS)) u_cordic_hip (
        .aclk      (aclk),
        .en        (en),
        .in_y      (sc_side[27:14]),
        .in_x      (sc_side[13:0]),
        .out_angle (ang_hip)
    );

    legik_cordic #(.IN_W(34), .STEPS(CORDIC_STEPS)) u_cordic_kacos (
        .aclk      (aclk),
        .en        (en),
        .in_y      ($signed({4'b0000, sc_root})),
        .in_x      (sc_side[93:60]),
        .out_angle (ang_kacos)
    );

    legik_cordic #(.IN_W(17), .STEPS(CORDIC_STEPS)) u_cordic_kdir (
        .aclk      (aclk),
        .en        (en),
        .in_y      (sc_side[59:43]),
        .in_x      (kd_x),
        .out_angle (ang_kdir)
    );

    legik_cordic #(.IN_W(34), .STEPS(CORDIC_STEPS)) u_cordic_ankle (
        .aclk      (aclk),
        .en        (en),
        .in_y      ($signed({4'b0000, sd_root})),
        .in_x      (sd_side[34:1]),
        .out_angle (ang_ankle)
    );

    logic cd_valid_reg [0:CORDIC_STEPS];
    logic cd_bad_reg   [0:CORDIC_STEPS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i <= CORDIC_STEPS; i++) begin
                cd_valid_reg[i] <= 1'b0;
            end
        end else if (en) begin
            cd_valid_reg[0] <= sc_valid & sd_valid;
            for (int i = 1; i <= CORDIC_STEPS; i++) begin
                cd_valid_reg[i] <= cd_valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cd_bad_reg[0] <= sd_side[0];
            for (int i = 1; i <= CORDIC_STEPS; i++) begin
                cd_bad_reg[i] <= cd_bad_reg[i-1];
            end
        end
    end

    // Final stage: sum, wrap and round the angles.
    logic                               p9_valid_reg;
    logic [47:0]                        p9_data_reg;
    logic                               p9_bad_reg;
    logic signed [legik_pkg::SUM_W-1:0] kn_sum;
    logic signed [legik_pkg::SUM_W-1:0] kn_wrap;
    logic signed [legik_pkg::SUM_W-1:0] an_sum;
    logic signed [legik_pkg::SUM_W-1:0] hp_sum;
    logic [47:0]                        data_next;

    always_comb begin
        kn_sum = 26'(ang_kacos) + 26'(ang_kdir) - 26'(legik_pkg::HALF_PI_Q);
        an_sum = 26'(ang_ankle) - 26'(legik_pkg::HALF_PI_Q);
        hp_sum = 26'(ang_hip);
        priority if (kn_sum < -legik_pkg::PI_Q) begin
            kn_wrap = kn_sum + legik_pkg::TWO_PI_Q;
        end else if (kn_sum > legik_pkg::PI_Q) begin
            kn_wrap = kn_sum - legik_pkg::TWO_PI_Q;
        end else begin
            kn_wrap = kn_sum;
        end
        if (cd_bad_reg[CORDIC_STEPS]) begin
            data_next = '0;
        end else begin
            data_next = {legik_pkg::round_angle(an_sum),
                         legik_pkg::round_angle(kn_wrap),
                         legik_pkg::round_angle(hp_sum)};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p9_valid_reg <= 1'b0;
        end else if (en) begin
            p9_valid_reg <= cd_valid_reg[CORDIC_STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p9_data_reg <= data_next;
            p9_bad_reg  <= cd_bad_reg[CORDIC_STEPS];
        end
    end

    // Output register with one skid entry.
    logic        out_valid_reg;
    logic [47:0] out_data_reg;
    logic        out_user_reg;
    logic [47:0] skid_data_reg;
    logic        skid_user_reg;

    assign out_free = ~out_valid_reg | m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (out_free) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end else if (p9_valid_reg) begin
            if (out_free) begin
                out_valid_reg <= 1'b1;
            end else begin
                skid_valid_reg <= 1'b1;
            end
        end else if (out_free) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (out_free) begin
                out_data_reg <= skid_data_reg;
                out_user_reg <= skid_user_reg;
            end
        end else if (p9_valid_reg) begin
            if (out_free) begin
                out_data_reg <= p9_data_reg;
                out_user_reg <= p9_bad_reg;
            end else begin
                skid_data_reg <= p9_data_reg;
                skid_user_reg <= p9_bad_reg;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held while the output register is empty");

    a_unreach_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_user_reg |-> out_data_reg == '0)
        else $error("unreachable item carries nonzero angles");

    a_skid_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg && !m_tready |=> skid_valid_reg && $stable(skid_data_reg))
        else $error("skid entry lost while the output is stalled");

endmodule

// ===== rtl/legik_isqrt.sv =====
module legik_isqrt #(
    parameter int IN_W   = 30,
    parameter int SIDE_W = 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [IN_W-1:0]   in_rad,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [IN_W/2-1:0] out_root,
    output logic [SIDE_W-1:0] out_side
);

    localparam int RT_W = IN_W / 2;
    localparam int RM_W = RT_W + 2;

    logic [IN_W-1:0]   rad_reg   [1:RT_W-1];
    logic [RM_W-1:0]   rem_reg   [1:RT_W-1];
    logic [RT_W-1:0]   root_reg  [1:RT_W];
    logic [SIDE_W-1:0] side_reg  [1:RT_W];
    logic              valid_reg [1:RT_W];

    for (genvar k = 1; k <= RT_W; k++) begin : g_step
        logic [IN_W-1:0]   rad_prev;
        logic [RM_W-1:0]   rem_prev;
        logic [RT_W-1:0]   root_prev;
        logic [SIDE_W-1:0] side_prev;
        logic              valid_prev;
        logic [RM_W+1:0]   cat;
        logic [RM_W+1:0]   trial;
        logic              ge;

        if (k == 1) begin : g_first
            assign rad_prev   = in_rad;
            assign rem_prev   = '0;
            assign root_prev  = '0;
            assign side_prev  = in_side;
            assign valid_prev = in_valid;
        end else begin : g_later
            assign rad_prev   = rad_reg[k-1];
            assign rem_prev   = rem_reg[k-1];
            assign root_prev  = root_reg[k-1];
            assign side_prev  = side_reg[k-1];
            assign valid_prev = valid_reg[k-1];
        end

        assign cat   = {rem_prev, rad_prev[IN_W-1 -: 2]};
        assign trial = {2'b00, root_prev, 2'b01};
        assign ge    = cat >= trial;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (en) begin
                valid_reg[k] <= valid_prev;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                root_reg[k] <= {root_prev[RT_W-2:0], ge};
                side_reg[k] <= side_prev;
            end
        end

        if (k < RT_W) begin : g_rem
            always_ff @(posedge aclk) begin
                if (en) begin
                    rad_reg[k] <= rad_prev << 2;
                    rem_reg[k] <= ge ? RM_W'(cat - trial) : RM_W'(cat);
                end
            end
        end
    end

    assign out_valid = valid_reg[RT_W];
    assign out_root  = root_reg[RT_W];
    assign out_side  = side_reg[RT_W];

endmodule

// ===== rtl/legik_cordic.sv =====
module legik_cordic #(
    parameter int IN_W  = 14,
    parameter int STEPS = legik_pkg::CORDIC_STEPS_DEF
) (
    input  logic                                aclk,
    input  logic                                en,
    input  logic signed [IN_W-1:0]              in_y,
    input  logic signed [IN_W-1:0]              in_x,
    output logic signed [legik_pkg::ANG_W-1:0]  out_angle
);

    localparam int W  = IN_W + 23;
    localparam int AW = legik_pkg::ANG_W;

    logic signed [W-1:0]  x_reg    [0:STEPS-2];
    logic signed [W-1:0]  y_reg    [0:STEPS-1];
    logic signed [AW-1:0] ang_reg  [0:STEPS];
    logic                 zero_reg [0:STEPS];

    logic signed [W-1:0]  xs;
    logic signed [W-1:0]  ys;
    logic signed [W-1:0]  x0_next;
    logic signed [W-1:0]  y0_next;
    logic signed [AW-1:0] ang0_next;

    // Vectors in the left half plane are first turned by a quarter turn.
    always_comb begin
        xs        = W'(in_x) <<< 20;
        ys        = W'(in_y) <<< 20;
        x0_next   = xs;
        y0_next   = ys;
        ang0_next = '0;
        if (xs < 0) begin
            if (ys >= 0) begin
                x0_next   = ys;
                y0_next   = -xs;
                ang0_next = legik_pkg::HALF_PI_Q;
            end else begin
                x0_next   = -ys;
                y0_next   = xs;
                ang0_next = -legik_pkg::HALF_PI_Q;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg[0]    <= x0_next;
            y_reg[0]    <= y0_next;
            ang_reg[0]  <= ang0_next;
            zero_reg[0] <= (in_x == '0) && (in_y == '0);
        end
    end

    for (genvar k = 1; k <= STEPS; k++) begin : g_step
        logic                 y_neg;
        logic signed [AW-1:0] ang_next;

        assign y_neg    = y_reg[k-1][W-1];
        assign ang_next = y_neg ? ang_reg[k-1] - legik_pkg::ATAN_TAB[k-1]
                                : ang_reg[k-1] + legik_pkg::ATAN_TAB[k-1];

        always_ff @(posedge aclk) begin
            if (en) begin
                ang_reg[k]  <= ang_next;
                zero_reg[k] <= zero_reg[k-1];
            end
        end

        if (k < STEPS) begin : g_y
            logic signed [W-1:0] dy;
            logic signed [W-1:0] y_next;
            assign dy     = x_reg[k-1] >>> (k-1);
            assign y_next = y_neg ? y_reg[k-1] + dy : y_reg[k-1] - dy;
            always_ff @(posedge aclk) begin
                if (en) begin
                    y_reg[k] <= y_next;
                end
            end
        end

        if (k < STEPS - 1) begin : g_x
            logic signed [W-1:0] dx;
            logic signed [W-1:0] x_next;
            assign dx     = y_reg[k-1] >>> (k-1);
            assign x_next = y_neg ? x_reg[k-1] - dx : x_reg[k-1] + dx;
            always_ff @(posedge aclk) begin
                if (en) begin
                    x_reg[k] <= x_next;
                end
            end
        end
    end

    assign out_angle = zero_reg[STEPS] ? '0 : ang_reg[STEPS];

endmodule
